// File: hw/rtl/ham6_pkg.sv
// Shared types and constants for the HAM6 pixel encoder.
package ham6_pkg;

  // One 4-bit-per-channel colour.
  typedef struct packed {
    logic [3:0] b;
    logic [3:0] g;
    logic [3:0] r;
  } rgb_t;

  // Channel selector of the modify path.
  typedef logic [1:0] chan_t;
  localparam chan_t CH_RED   = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

  // HAM6 modify codes: upper two pen bits.
  localparam logic [5:0] MOD_BLUE  = 6'h10;
  localparam logic [5:0] MOD_RED   = 6'h20;
  localparam logic [5:0] MOD_GREEN = 6'h30;

  // Manhattan distance over three 4-bit channels fits in 6 bits.
  localparam int unsigned DIST_W = 6;
  typedef logic [DIST_W-1:0] dist_t;
  localparam dist_t DIST_FAR = '1;

  // Reset colours of the two fixed palette entries.
  localparam rgb_t COL_BLACK = '{b: 4'h0, g: 4'h0, r: 4'h0};
  localparam rgb_t COL_WHITE = '{b: 4'hF, g: 4'hF, r: 4'hF};

  // Field packing of the result word.
  typedef struct packed {
    logic [1:0] pad;
    logic [3:0] palette_blue;
    logic [3:0] palette_green;
    logic [3:0] palette_red;
    logic [3:0] palette_index;
    logic [5:0] pen;
  } out_data_t;

  typedef struct packed {
    logic palette_write;
    logic used_palette;
  } out_user_t;

endpackage

// File: hw/rtl/ham6_pixel_encoder_top.sv
// Top level of the HAM6 pixel encoder: sequencer, palette memory and shared distance unit.
//
// HAM6 pixel encoder. Each input word is one pixel (red, green, blue, 4 bits each)
// plus a first-of-line flag on s_tuser; each pixel gives exactly one result word
// holding a 6-bit hold-and-modify pen, whether it is a palette index, and any
// palette entry the pixel allocated (index and colour; all zero when none).
// The pixel is handled by a small sequencer around one shared three-channel
// absolute-difference/sum/max unit: a decide step against the held colour, then
// a scan comparing one palette entry per cycle through the single registered read port of
// the palette memory, then a finish step that allocates, updates the held colour
// and loads the output register. A pixel that neither starts a line, differs from
// the held colour in more than one channel, nor follows a palette pen skips the
// scan. s_tready is high only while the sequencer is idle; a finished word may
// wait in the output register while the next pixel is already being worked on,
// and only the finish step waits for it to be taken. alloc_threshold is written
// on the cfg channel (always ready) and must only change while no pixel is in
// flight. Entries 0 and 1 (black, white) are fixed, so the palette needs no
// clearing pass after reset.
module ham6_pixel_encoder_top #(
  parameter int unsigned PALETTE_ENTRIES = 16   // 2..16
) (
  input  logic        clk,
  input  logic        rst,
  // pixel stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // red[3:0], green[7:4], blue[11:8], zero pad[15:12]
  input  logic        s_tuser,   // first_of_line
  // pen stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pen[5:0], palette_index[9:6], palette_red[13:10],
                                 // palette_green[17:14], palette_blue[21:18], zero[23:22]
  output logic [1:0]  m_tuser,   // used_palette[0], palette_write[1]
  // threshold register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data   // alloc_threshold
);
  import ham6_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(PALETTE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]       state, state_next;
  logic [5:0]       alloc_threshold;
  logic [CNT_W-1:0] entries_used;
  rgb_t             held;
  logic             last_was_palette;

  // current pixel
  rgb_t             pix;
  logic             first_of_line;
  logic [4:0]       d_held;        // distance to held colour less worst channel
  logic             lookup_done;

  // scan
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] best;
  dist_t            bestd;
  rgb_t             best_col;

  // palette memory, one write and one registered read port
  logic [11:0]      mem [PALETTE_ENTRIES];
  logic [11:0]      mem_q;
  logic [IDX_W-1:0] rd_addr, rd_addr_q;
  rgb_t             rd_col;
  logic             wr_en;

  // output register
  out_data_t        out_data;
  out_user_t        out_user;

  // ---------------------------------------------------------------
  // shared distance unit: per-channel |a-b|, sum, largest and its channel
  rgb_t       unit_ref;
  logic [3:0] e_r, e_g, e_b, e_max;
  dist_t      e_sum;
  chan_t      e_id;
  logic [4:0] e_rest;

  assign unit_ref = (state == S_SCAN) ? rd_col : held;

  always_comb begin
    e_r   = (pix.r > unit_ref.r) ? pix.r - unit_ref.r : unit_ref.r - pix.r;
    e_g   = (pix.g > unit_ref.g) ? pix.g - unit_ref.g : unit_ref.g - pix.g;
    e_b   = (pix.b > unit_ref.b) ? pix.b - unit_ref.b : unit_ref.b - pix.b;
    e_sum = DIST_W'(e_r) + DIST_W'(e_g) + DIST_W'(e_b);
    e_max = e_r;
    e_id  = CH_RED;
    if (e_g > e_max) begin
      e_max = e_g;
      e_id  = CH_GREEN;
    end
    if (e_b > e_max) begin
      e_max = e_b;
      e_id  = CH_BLUE;
    end
    e_rest = 5'(e_sum - DIST_W'(e_max));
  end

  // ---------------------------------------------------------------
  // palette read: entries 0 and 1 are fixed colours
  logic scan_last;
  assign scan_last = (CNT_W'(scan_idx) == entries_used - CNT_W'(1));
  assign rd_addr   = (state == S_SCAN && !scan_last) ? scan_idx + IDX_W'(1) : '0;

  always_ff @(posedge clk) begin
    mem_q     <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    if (wr_en) begin
      mem[entries_used[IDX_W-1:0]] <= pix;
    end
  end

  always_comb begin
    if (rd_addr_q == IDX_W'(0)) begin
      rd_col = COL_BLACK;
    end else if (rd_addr_q == IDX_W'(1)) begin
      rd_col = COL_WHITE;
    end else begin
      rd_col = rgb_t'(mem_q);
    end
  end

  // ---------------------------------------------------------------
  // finish step decisions
  logic  out_free;
  logic  do_alloc;
  dist_t final_d;
  logic  use_pal;
  logic  finish_go;
  logic [5:0] mod_pen;
  rgb_t  held_next;

  assign out_free  = !m_tvalid || m_tready;
  assign finish_go = (state == S_FINISH) && out_free;
  assign do_alloc  = lookup_done && (bestd > DIST_W'(alloc_threshold))
                     && (entries_used < CNT_FULL);
  assign final_d   = do_alloc ? '0 : bestd;
  assign wr_en     = finish_go && do_alloc;

  always_comb begin
    if (first_of_line) begin
      use_pal = 1'b1;
    end else if (d_held != 5'd0) begin
      use_pal = final_d < DIST_W'(d_held);
    end else begin
      use_pal = last_was_palette;
    end
  end

  always_comb begin
    held_next = held;
    mod_pen   = MOD_RED + 6'(pix.r);
    if (use_pal) begin
      held_next = do_alloc ? pix : best_col;
    end else begin
      case (e_id)
        CH_GREEN: begin
          mod_pen     = MOD_GREEN + 6'(pix.g);
          held_next.g = pix.g;
        end
        CH_BLUE: begin
          mod_pen     = MOD_BLUE + 6'(pix.b);
          held_next.b = pix.b;
        end
        default: begin
          held_next.r = pix.r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (first_of_line || e_rest != 5'd0 || last_was_palette) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN:   if (scan_last) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      alloc_threshold  <= 6'd4;
      entries_used     <= CNT_RESET;
      held             <= COL_BLACK;
      last_was_palette <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        alloc_threshold <= cfg_data;
      end
      // a new word replaces one taken in the same cycle
      if (finish_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (finish_go) begin
        held             <= held_next;
        last_was_palette <= use_pal;
        if (do_alloc) begin
          entries_used <= entries_used + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix.r         <= s_tdata[3:0];
      pix.g         <= s_tdata[7:4];
      pix.b         <= s_tdata[11:8];
      first_of_line <= s_tuser;
    end
    if (state == S_DECIDE) begin
      d_held      <= e_rest;
      lookup_done <= first_of_line || e_rest != 5'd0 || last_was_palette;
      scan_idx    <= '0;
      best        <= '0;
      bestd       <= DIST_FAR;
      best_col    <= COL_BLACK;
    end
    if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (e_sum < bestd) begin
        bestd    <= e_sum;
        best     <= scan_idx;
        best_col <= rd_col;
      end
    end
    if (finish_go) begin
      out_data.pad           <= '0;
      out_data.pen           <= use_pal ? (do_alloc ? 6'(entries_used) : 6'(best)) : mod_pen;
      out_data.palette_index <= do_alloc ? 4'(entries_used) : 4'd0;
      out_data.palette_red   <= do_alloc ? pix.r : 4'd0;
      out_data.palette_green <= do_alloc ? pix.g : 4'd0;
      out_data.palette_blue  <= do_alloc ? pix.b : 4'd0;
      out_user.used_palette  <= use_pal;
      out_user.palette_write <= do_alloc;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_user;

  // ---------------------------------------------------------------
  // assertions
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    entries_used >= CNT_RESET && entries_used <= CNT_FULL)
    else $error("palette fill count out of range");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (entries_used == $past(entries_used)
                     || entries_used == $past(entries_used) + CNT_W'(1)))
    else $error("palette fill count jumped");

  a_write_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> 5'(m_tdata[9:6]) == 5'(entries_used - CNT_W'(1)))
    else $error("reported palette write is not the last allocated entry");

  a_modify_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[5:4] != 2'b00)
    else $error("modify pen without a modify code");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer took a second pixel while busy");

endmodule
